FILE: hw/rtl/nalr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nalr_pkg
// Shared constants, types and helpers for the nice axis label range block.
// ----------------------------------------------------------------------------
package nalr_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TICK_WIDTH  = 7;
  localparam int MANT_WIDTH  = 3;
  localparam int EXP_WIDTH   = 5;
  localparam int INDEX_WIDTH = 39;
  localparam int DIV_WIDTH   = 39;
  localparam int POW_WIDTH   = 40;
  localparam int DECADES     = 10;
  localparam int NICE_COUNT  = 3 * DECADES;

  localparam logic [TICK_WIDTH-1:0] TICK_RESET = 7'd10;

  localparam logic [MANT_WIDTH-1:0] MANT_ONE  = 3'd1;
  localparam logic [MANT_WIDTH-1:0] MANT_TWO  = 3'd2;
  localparam logic [MANT_WIDTH-1:0] MANT_FIVE = 3'd5;

  typedef struct packed {
    logic                        err;
    logic [MANT_WIDTH-1:0]       mant;
    logic signed [EXP_WIDTH-1:0] exp10;
    logic                        lo_neg;
    logic                        hi_neg;
  } side_t;

  function automatic logic [POW_WIDTH-1:0] pow10(input logic [3:0] e);
    logic [POW_WIDTH-1:0] p;
    case (e)
      4'd0:    p = 40'd1;
      4'd1:    p = 40'd10;
      4'd2:    p = 40'd100;
      4'd3:    p = 40'd1000;
      4'd4:    p = 40'd10000;
      4'd5:    p = 40'd100000;
      4'd6:    p = 40'd1000000;
      4'd7:    p = 40'd10000000;
      4'd8:    p = 40'd100000000;
      4'd9:    p = 40'd1000000000;
      4'd10:   p = 40'd10000000000;
      4'd11:   p = 40'd100000000000;
      default: p = 40'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/nice_axis_label_range.sv
`default_nettype none
// Pipeline from input transaction to result: 6 setup stages, 39 divider
// stages, one output register.
// Throughput: one transaction per cycle; the pipeline advances as a whole
// whenever the output register is empty or being taken.
// Reset: rst clears all valid bits and sets tick_count to 10.
// ----------------------------------------------------------------------------
// nice_axis_label_range
// Loose axis labeling with 1-2-5 step spacing and floor/ceil step indices.
// ----------------------------------------------------------------------------
module nice_axis_label_range import nalr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [TICK_WIDTH-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] min_value,
  input  wire logic signed [VALUE_WIDTH-1:0] max_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [MANT_WIDTH-1:0]              step_mantissa,
  output logic signed [EXP_WIDTH-1:0]        step_exponent,
  output logic signed [INDEX_WIDTH-1:0]      low_index,
  output logic signed [INDEX_WIDTH-1:0]      high_index,
  output logic                               range_error
);

  logic                  en;
  logic [TICK_WIDTH-1:0] tick_count;
  logic                  f_valid, d_valid;
  side_t                 f_side, d_side;
  logic [DIV_WIDTH-1:0]  f_lo, f_hi, f_den, q_lo, q_hi;
  logic                  rnz_lo, rnz_hi;
  logic [DIV_WIDTH-1:0]  lo_up, hi_up;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= TICK_RESET;
    end else if (cfg_we) begin
      tick_count <= cfg_data;
    end
  end

  nalr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .min_value  (min_value),
    .max_value  (max_value),
    .tick_count (tick_count),
    .valid      (f_valid),
    .side       (f_side),
    .lo_mag     (f_lo),
    .hi_mag     (f_hi),
    .den        (f_den)
  );

  nalr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .a_lo      (f_lo),
    .a_hi      (f_hi),
    .d         (f_den),
    .out_valid (d_valid),
    .out_side  (d_side),
    .q_lo      (q_lo),
    .q_hi      (q_hi),
    .rnz_lo    (rnz_lo),
    .rnz_hi    (rnz_hi)
  );

  assign lo_up = q_lo + DIV_WIDTH'(rnz_lo);
  assign hi_up = q_hi + DIV_WIDTH'(rnz_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_error <= d_side.err;
      if (d_side.err) begin
        step_mantissa <= '0;
        step_exponent <= '0;
        low_index     <= '0;
        high_index    <= '0;
      end else begin
        step_mantissa <= d_side.mant;
        step_exponent <= d_side.exp10;
        low_index     <= d_side.lo_neg ? INDEX_WIDTH'(-lo_up) : INDEX_WIDTH'(q_lo);
        high_index    <= d_side.hi_neg ? INDEX_WIDTH'(-q_hi) : INDEX_WIDTH'(hi_up);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> step_mantissa == '0 && low_index == '0 && high_index == '0)
    else $error("error result carries nonzero fields");

  a_mant: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |->
      step_mantissa == MANT_ONE || step_mantissa == MANT_TWO || step_mantissa == MANT_FIVE)
    else $error("step mantissa not 1, 2 or 5");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |-> low_index < high_index)
    else $error("low index not below high index");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/nalr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nalr_front
// Six-stage front end: span, nice ceiling, step rounding and divisor setup.
// ----------------------------------------------------------------------------
module nalr_front import nalr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [VALUE_WIDTH-1:0] min_value,
  input  wire logic signed [VALUE_WIDTH-1:0] max_value,
  input  wire logic [TICK_WIDTH-1:0]         tick_count,
  output logic                               valid,
  output side_t                              side,
  output logic [DIV_WIDTH-1:0]               lo_mag,
  output logic [DIV_WIDTH-1:0]               hi_mag,
  output logic [DIV_WIDTH-1:0]               den
);

  logic [5:0] v;

  // stage 1
  logic signed [VALUE_WIDTH-1:0] s1_lo, s1_hi;
  logic                          s1_err;
  logic [VALUE_WIDTH-1:0]        s1_span;
  logic [TICK_WIDTH-1:0]         s1_nn;
  logic [VALUE_WIDTH:0]          span_full;

  assign span_full = {max_value[VALUE_WIDTH-1], max_value}
                   - {min_value[VALUE_WIDTH-1], min_value};

  // stage 2
  logic signed [VALUE_WIDTH-1:0] s2_lo, s2_hi;
  logic                          s2_err;
  logic [TICK_WIDTH-1:0]         s2_nn;
  logic [NICE_COUNT-1:0]         s2_t;
  logic [DECADES-1:0]            s2_t5;
  logic [NICE_COUNT-1:0]         t_next;
  logic [DECADES-1:0]            t5_next;

  always_comb begin
    for (int i = 0; i < DECADES; i++) begin
      t_next[3*i]   = pow10(4'(i)) < POW_WIDTH'(s1_span);
      t_next[3*i+1] = (pow10(4'(i)) << 1) < POW_WIDTH'(s1_span);
      t_next[3*i+2] = POW_WIDTH'(pow10(4'(i)) * 40'd5) < POW_WIDTH'(s1_span);
      t5_next[i]    = t_next[3*i+2];
    end
  end

  // stage 3
  logic signed [VALUE_WIDTH-1:0] s3_lo, s3_hi;
  logic                          s3_err;
  logic [TICK_WIDTH-1:0]         s3_nn;
  logic [3:0]                    s3_k;
  logic [13:0]                   s3_r;
  logic [4:0]                    n_cnt;
  logic [3:0]                    k_cnt;
  logic [4:0]                    c_sel;
  logic [13:0]                   r_next;

  always_comb begin
    n_cnt = 5'($countones(s2_t));
    k_cnt = 4'($countones(s2_t5));
    c_sel = n_cnt - 5'(3 * k_cnt);
    case (c_sel)
      5'd0:    r_next = 14'd1000;
      5'd1:    r_next = 14'd2000;
      default: r_next = 14'd5000;
    endcase
  end

  // stage 4
  logic signed [VALUE_WIDTH-1:0] s4_lo, s4_hi;
  logic                          s4_err;
  logic [13:0]                   s4_r;
  logic [20:0]                   s4_pn;
  logic signed [EXP_WIDTH-1:0]   s4_exp;
  logic [20:0]                   pj [5];
  logic [3:0]                    ge;
  logic [2:0]                    j_cnt;
  logic [20:0]                   pn_next;

  always_comb begin
    pj[0] = 21'(s3_nn);
    pj[1] = 21'(s3_nn) * 21'd10;
    pj[2] = 21'(s3_nn) * 21'd100;
    pj[3] = 21'(s3_nn) * 21'd1000;
    pj[4] = 21'(s3_nn) * 21'd10000;
    for (int j = 0; j < 4; j++) ge[j] = pj[j+1] <= 21'(s3_r);
    j_cnt = 3'($countones(ge));
    pn_next = pj[j_cnt];
  end

  // stage 5
  logic signed [VALUE_WIDTH-1:0] s5_lo, s5_hi;
  logic                          s5_err;
  logic [MANT_WIDTH-1:0]         s5_mant;
  logic signed [EXP_WIDTH-1:0]   s5_exp;
  logic [23:0]                   a1, a2, p3, p7;
  logic [MANT_WIDTH-1:0]         mant_next;
  logic signed [EXP_WIDTH-1:0]   exp_next;

  always_comb begin
    a1 = 24'(s4_r);
    a2 = 24'(s4_r) << 1;
    p3 = 24'(s4_pn) * 24'd3;
    p7 = 24'(s4_pn) * 24'd7;
    exp_next = s4_exp;
    if (a2 < p3) begin
      mant_next = MANT_ONE;
    end else if (a1 < p3) begin
      mant_next = MANT_TWO;
    end else if (a1 < p7) begin
      mant_next = MANT_FIVE;
    end else begin
      mant_next = MANT_ONE;
      exp_next  = s4_exp + 5'sd1;
    end
  end

  // stage 6
  logic [VALUE_WIDTH:0]     lo_abs, hi_abs;
  logic [6:0]               mul;
  logic [DIV_WIDTH-1:0]     den_next;
  logic [EXP_WIDTH-1:0]     neg_exp;

  always_comb begin
    neg_exp = EXP_WIDTH'(-s5_exp);
    lo_abs  = s5_lo[VALUE_WIDTH-1] ? (VALUE_WIDTH+1)'(-{s5_lo[VALUE_WIDTH-1], s5_lo})
                                   : (VALUE_WIDTH+1)'({1'b0, s5_lo});
    hi_abs  = s5_hi[VALUE_WIDTH-1] ? (VALUE_WIDTH+1)'(-{s5_hi[VALUE_WIDTH-1], s5_hi})
                                   : (VALUE_WIDTH+1)'({1'b0, s5_hi});
    if (!s5_exp[EXP_WIDTH-1]) begin
      den_next = DIV_WIDTH'(pow10(s5_exp[3:0]) * POW_WIDTH'(s5_mant));
      mul      = 7'd1;
    end else begin
      den_next = DIV_WIDTH'(s5_mant);
      mul      = 7'(pow10(neg_exp[3:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lo   <= min_value;
      s1_hi   <= max_value;
      s1_err  <= !(min_value < max_value);
      s1_span <= span_full[VALUE_WIDTH-1:0];
      s1_nn   <= (tick_count < 7'd2) ? 7'd1 : tick_count - 7'd1;

      s2_lo  <= s1_lo;
      s2_hi  <= s1_hi;
      s2_err <= s1_err;
      s2_nn  <= s1_nn;
      s2_t   <= t_next;
      s2_t5  <= t5_next;

      s3_lo  <= s2_lo;
      s3_hi  <= s2_hi;
      s3_err <= s2_err;
      s3_nn  <= s2_nn;
      s3_k   <= k_cnt;
      s3_r   <= r_next;

      s4_lo  <= s3_lo;
      s4_hi  <= s3_hi;
      s4_err <= s3_err;
      s4_r   <= s3_r;
      s4_pn  <= pn_next;
      s4_exp <= EXP_WIDTH'(s3_k) + EXP_WIDTH'(j_cnt) - 5'sd3;

      s5_lo   <= s4_lo;
      s5_hi   <= s4_hi;
      s5_err  <= s4_err;
      s5_mant <= mant_next;
      s5_exp  <= exp_next;

      side.err    <= s5_err;
      side.mant   <= s5_mant;
      side.exp10  <= s5_exp;
      side.lo_neg <= s5_lo[VALUE_WIDTH-1];
      side.hi_neg <= s5_hi[VALUE_WIDTH-1];
      lo_mag      <= DIV_WIDTH'(lo_abs * mul);
      hi_mag      <= DIV_WIDTH'(hi_abs * mul);
      den         <= s5_err ? DIV_WIDTH'(1) : den_next;
    end
  end

  assign valid = v[5];

endmodule
`default_nettype wire

FILE: hw/rtl/nalr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nalr_div
// Pipelined restoring divider, one quotient bit per stage, two dividends.
// ----------------------------------------------------------------------------
module nalr_div import nalr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire side_t                in_side,
  input  wire logic [DIV_WIDTH-1:0] a_lo,
  input  wire logic [DIV_WIDTH-1:0] a_hi,
  input  wire logic [DIV_WIDTH-1:0] d,
  output logic                      out_valid,
  output side_t                     out_side,
  output logic [DIV_WIDTH-1:0]      q_lo,
  output logic [DIV_WIDTH-1:0]      q_hi,
  output logic                      rnz_lo,
  output logic                      rnz_hi
);

  localparam int W = DIV_WIDTH;

  logic [W-1:0] v;
  side_t        sd     [W];
  logic [W-1:0] dd     [W];
  logic [W-1:0] rem_lo [W];
  logic [W-1:0] aq_lo  [W];
  logic [W-1:0] rem_hi [W];
  logic [W-1:0] aq_hi  [W];

  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                              input logic [W-1:0] aq,
                                              input logic [W-1:0] dv);
    logic [W:0]   t;
    logic [W-1:0] r;
    logic         qb;
    t  = {rem, aq[W-1]};
    qb = t >= {1'b0, dv};
    r  = qb ? W'(t - {1'b0, dv}) : t[W-1:0];
    return {r, aq[W-2:0], qb};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[W-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0] prem_lo, paq_lo, prem_hi, paq_hi, pd;
    side_t        psd;
    if (i == 0) begin : g_first
      assign prem_lo = '0;
      assign paq_lo  = a_lo;
      assign prem_hi = '0;
      assign paq_hi  = a_hi;
      assign pd      = d;
      assign psd     = in_side;
    end else begin : g_rest
      assign prem_lo = rem_lo[i-1];
      assign paq_lo  = aq_lo[i-1];
      assign prem_hi = rem_hi[i-1];
      assign paq_hi  = aq_hi[i-1];
      assign pd      = dd[i-1];
      assign psd     = sd[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        {rem_lo[i], aq_lo[i]} <= div_step(prem_lo, paq_lo, pd);
        {rem_hi[i], aq_hi[i]} <= div_step(prem_hi, paq_hi, pd);
        dd[i] <= pd;
        sd[i] <= psd;
      end
    end
  end

  assign out_valid = v[W-1];
  assign out_side  = sd[W-1];
  assign q_lo      = aq_lo[W-1];
  assign q_hi      = aq_hi[W-1];
  assign rnz_lo    = |rem_lo[W-1];
  assign rnz_hi    = |rem_hi[W-1];

endmodule
`default_nettype wire

FILE: bench/nice_axis_label_range_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nice_axis_label_range_checker
// Watches the input and result channels of the nice axis label block,
// computes the expected spacing and step indices for every accepted
// transaction and compares each result field with the oldest expectation.
// ----------------------------------------------------------------------------
module nice_axis_label_range_checker import nalr_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [TICK_WIDTH-1:0]         cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] min_value,
  input  wire logic signed [VALUE_WIDTH-1:0] max_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [MANT_WIDTH-1:0]         step_mantissa,
  input  wire logic signed [EXP_WIDTH-1:0]   step_exponent,
  input  wire logic signed [INDEX_WIDTH-1:0] low_index,
  input  wire logic signed [INDEX_WIDTH-1:0] high_index,
  input  wire logic                          range_error,
  output int                                 fail_count,
  output int                                 pending_count
);

  typedef struct packed {
    logic [MANT_WIDTH-1:0]        mant;
    logic signed [EXP_WIDTH-1:0]  exp10;
    logic signed [INDEX_WIDTH-1:0] lo_idx;
    logic signed [INDEX_WIDTH-1:0] hi_idx;
    logic                         err;
  } axis_t;

  axis_t axis_q[$];
  logic [TICK_WIDTH-1:0] ticks;

  function automatic longint floor_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint ceil_quot(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a > 0) q = q + 1;
    return q;
  endfunction

  function automatic axis_t nice_axis(longint lo, longint hi, int tc);
    axis_t r;
    longint span, p10, rng, nn, s, q, p, pn, den, mul;
    int e;
    r = '0;
    if (lo >= hi) begin
      r.err = 1'b1;
      return r;
    end
    span = hi - lo;
    p10 = 1;
    while (p10 <= span / 10) p10 = p10 * 10;
    if (span <= p10) rng = p10;
    else if (span <= 2 * p10) rng = 2 * p10;
    else if (span <= 5 * p10) rng = 5 * p10;
    else rng = 10 * p10;
    nn = ((tc < 2) ? 2 : tc) - 1;
    s = rng * 1000;
    q = s / nn;
    p = 1;
    e = -3;
    while (p * 10 <= q) begin
      p = p * 10;
      e++;
    end
    pn = p * nn;
    if (2 * s < 3 * pn) r.mant = MANT_ONE;
    else if (s < 3 * pn) r.mant = MANT_TWO;
    else if (s < 7 * pn) r.mant = MANT_FIVE;
    else begin
      r.mant = MANT_ONE;
      e++;
    end
    den = longint'(r.mant);
    mul = 1;
    if (e >= 0) for (int k = 0; k < e; k++) den = den * 10;
    else for (int k = 0; k < -e; k++) mul = mul * 10;
    r.exp10 = EXP_WIDTH'(e);
    r.lo_idx = INDEX_WIDTH'(floor_quot(lo * mul, den));
    r.hi_idx = INDEX_WIDTH'(ceil_quot(hi * mul, den));
    return r;
  endfunction

  assign pending_count = axis_q.size();

  always @(posedge clk) begin
    axis_t want;
    if (rst) begin
      ticks <= TICK_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_we) ticks <= cfg_data;
      if (in_valid && in_ready)
        axis_q.push_back(nice_axis(longint'(min_value), longint'(max_value), int'(ticks)));
      if (out_valid && out_ready) begin
        if (axis_q.size() == 0) begin
          $error("result transaction with no expectation");
          fail_count <= fail_count + 1;
        end else begin
          want = axis_q.pop_front();
          if (step_mantissa !== want.mant || step_exponent !== want.exp10 ||
              low_index !== want.lo_idx || high_index !== want.hi_idx ||
              range_error !== want.err) begin
            fail_count <= fail_count + 1;
            if (step_mantissa !== want.mant)
              $error("step_mantissa exp %0d got %0d", want.mant, step_mantissa);
            if (step_exponent !== want.exp10)
              $error("step_exponent exp %0d got %0d", want.exp10, step_exponent);
            if (low_index !== want.lo_idx)
              $error("low_index exp %0d got %0d", want.lo_idx, low_index);
            if (high_index !== want.hi_idx)
              $error("high_index exp %0d got %0d", want.hi_idx, high_index);
            if (range_error !== want.err)
              $error("range_error exp %0d got %0d", want.err, range_error);
          end
        end
      end
    end
  end

endmodule

FILE: bench/nice_axis_label_range_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nice_axis_label_range_tb
// Drives directed and random min/max pairs through the axis label block
// under several tick counts and handshake idling patterns, including a long
// result stall; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module nice_axis_label_range_tb;
  import nalr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TICK_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VALUE_WIDTH-1:0] min_value = '0;
  logic signed [VALUE_WIDTH-1:0] max_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MANT_WIDTH-1:0] step_mantissa;
  logic signed [EXP_WIDTH-1:0] step_exponent;
  logic signed [INDEX_WIDTH-1:0] low_index;
  logic signed [INDEX_WIDTH-1:0] high_index;
  logic range_error;
  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cycles = 0;

  always #2 clk = ~clk;

  nice_axis_label_range uut (.*);
  nice_axis_label_range_checker checker_i (.*);

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 300;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pair(input logic signed [VALUE_WIDTH-1:0] lo,
                           input logic signed [VALUE_WIDTH-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    min_value <= lo;
    max_value <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_set(input logic [TICK_WIDTH-1:0] tc);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= tc;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_pair();
    logic signed [VALUE_WIDTH-1:0] a, b;
    int sz;
    a = $urandom;
    case ($urandom_range(4))
      0: b = $urandom;
      1: b = a;
      default: begin
        sz = $urandom_range(31);
        b = a + ($urandom & ((32'd1 << sz) - 1)) + 1;
        if (b < a) b = 32'h7fffffff;
      end
    endcase
    if ($urandom_range(9) == 0) send_pair(b, a);
    else send_pair(a, b);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_pair(32'sh80000000, 32'sh7fffffff);
    send_pair(0, 1);
    send_pair(5, 5);
    send_pair(7, 3);
    send_pair(-1, 0);
    send_pair(-1000, 1000);
    send_pair(0, 95);
    send_pair(0, 1000000000);
    send_pair(-7, 13);
    send_pair(32'sh7ffffffe, 32'sh7fffffff);
    send_pair(32'sh80000000, 32'sh80000001);
    drain_and_set(7'd0);
    send_pair(0, 1);
    send_pair(-3, 100);
    drain_and_set(7'd127);
    send_pair(0, 1);
    send_pair(32'sh80000000, 32'sh7fffffff);
    send_pair(-1, 2);
    drain_and_set(7'd2);
    send_pair(32'sh80000000, 32'sh7fffffff);
    send_pair(3, 17);
    send_pair(-999, -1);
    send_pair(12, 16);
    send_pair(0, 74);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 60 : 0;
      recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 37 : 0;
      for (int s = 0; s < 4; s++) begin
        drain_and_set((s == 0) ? 7'd64 : (s == 1) ? 7'd10 : 7'($urandom_range(127)));
        if (ph == 2 && s == 0) hold_req = 1'b1;
        for (int i = 0; i < 130; i++) random_pair();
      end
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: nice_axis_label_range.f
hw/rtl/nalr_pkg.sv
hw/rtl/nalr_front.sv
hw/rtl/nalr_div.sv
hw/rtl/nice_axis_label_range.sv
bench/nice_axis_label_range_checker.sv
bench/nice_axis_label_range_tb.sv
